FILE: src/jq_pkg.sv
// shared types and constants for the single server job queue
`default_nettype none

package jq_pkg;

  localparam int unsigned MINUTE_W = 16;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned WAIT_W   = 40;
  localparam int unsigned SVC_W    = 12;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [WAIT_W-1:0]  WAIT_MAX  = '1;
  localparam logic [SVC_W-1:0]   SVC_RESET = SVC_W'(1);

  typedef logic [MINUTE_W-1:0] minute_t;

  // queue commands for one tick
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  // per-tick result fields that do not depend on the queue depth
  typedef struct packed {
    minute_t              minute;
    logic [COUNT_W-1:0]   arrived_job;
    logic                 arrival_dropped;
    logic [COUNT_W-1:0]   job_in_service;
    logic                 busy_res;
    logic [COUNT_W-1:0]   jobs_done;
    logic [WAIT_W-1:0]    wait_total;
  } tick_res_t;

endpackage

`default_nettype wire

FILE: src/jq_if.sv
// request and result channel interfaces
`default_nettype none

interface jq_in_if;
  logic valid;
  logic ready;
  logic arrival;

  modport source (output valid, output arrival, input ready);
  modport sink   (input valid, input arrival, output ready);
endinterface

interface jq_out_if #(
  parameter int unsigned QUEUE_DEPTH = 4096
);
  localparam int unsigned QLEN_W = $clog2(QUEUE_DEPTH + 1);

  logic              valid;
  logic              ready;
  logic [15:0]       minute;
  logic [31:0]       arrived_job;
  logic              arrival_dropped;
  logic [31:0]       job_in_service;
  logic              busy_res;
  logic [QLEN_W-1:0] queue_length;
  logic [31:0]       jobs_done;
  logic [39:0]       wait_total;

  modport source (
    output valid, output minute, output arrived_job, output arrival_dropped,
    output job_in_service, output busy_res, output queue_length,
    output jobs_done, output wait_total, input ready
  );
  modport sink (
    input valid, input minute, input arrived_job, input arrival_dropped,
    input job_in_service, input busy_res, input queue_length,
    input jobs_done, input wait_total, output ready
  );
endinterface

`default_nettype wire

FILE: src/single_server_job_queue.sv
// single server job queue: a request goes through the request register, then the result register
// throughput one request per cycle while results are taken; the tick steps once per request
// that advances; queue ram read-ahead runs every cycle
// the next head is read from ram into a register, bypassed when that entry is written at once
// reset: async active low, clears minute, counters, countdown, queue pointers; service time 1
// queue ram contents are not cleared; no entry is used before it is written
`default_nettype none

module single_server_job_queue
  import jq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [SVC_W-1:0] cfg_data_i,
  jq_in_if.sink                 req_i,
  jq_out_if.source              res_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [SVC_W-1:0] svc_q;
  logic             in_valid_q;
  logic             arrival_q;
  logic             out_valid_q;
  tick_res_t        res_q;
  logic [CNT_W-1:0] qlen_q;
  logic             advance;

  fifo_ctrl_t       fifo_ctrl;
  minute_t          front;
  logic [CNT_W-1:0] count;
  tick_res_t        tick_res;
  logic [CNT_W-1:0] qlen;

  // service time register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      svc_q <= SVC_RESET;
    end else if (cfg_we_i) begin
      svc_q <= cfg_data_i;
    end
  end

  // a request moves on when the result register is free or being emptied
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      arrival_q <= req_i.arrival;
    end
  end

  jq_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fifo_ctrl),
    .push_data_i (tick_res.minute),
    .front_o     (front),
    .count_o     (count)
  );

  jq_tick #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_tick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .arrival_i  (arrival_q),
    .svc_time_i (svc_q),
    .count_i    (count),
    .front_i    (front),
    .ctrl_o     (fifo_ctrl),
    .res_o      (tick_res),
    .qlen_o     (qlen)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q  <= tick_res;
      qlen_q <= qlen;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.minute          = res_q.minute;
  assign res_o.arrived_job     = res_q.arrived_job;
  assign res_o.arrival_dropped = res_q.arrival_dropped;
  assign res_o.job_in_service  = res_q.job_in_service;
  assign res_o.busy_res        = res_q.busy_res;
  assign res_o.queue_length    = qlen_q;
  assign res_o.jobs_done       = res_q.jobs_done;
  assign res_o.wait_total      = res_q.wait_total;

endmodule

`default_nettype wire

FILE: src/jq_fifo.sv
// arrival minute queue: ram with read-ahead of the head entry
`default_nettype none

module jq_fifo
  import jq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4096
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire fifo_ctrl_t                         ctrl_i,
  input  wire minute_t                            push_data_i,
  output      minute_t                            front_o,
  output      logic [$clog2(QUEUE_DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  minute_t          mem_q [QUEUE_DEPTH];
  minute_t          rd_q;

  // pointer and count update
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      tail_d = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
    end
    if (ctrl_i.pop) begin
      head_d = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
    end
    unique case ({ctrl_i.push, ctrl_i.pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // ram write at tail, registered read of the next head with write bypass
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q] <= push_data_i;
    end
    if (ctrl_i.push && (tail_q == head_d)) begin
      rd_q <= push_data_i;
    end else begin
      rd_q <= mem_q[head_d];
    end
  end

  assign front_o = rd_q;
  assign count_o = count_q;

endmodule

`default_nettype wire

FILE: src/jq_tick.sv
// per-tick server state: minute, countdown, counters and wait total
`default_nettype none

module jq_tick
  import jq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4096
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               step_i,
  input  wire logic                               arrival_i,
  input  wire logic [SVC_W-1:0]                   svc_time_i,
  input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   count_i,
  input  wire minute_t                            front_i,
  output      fifo_ctrl_t                         ctrl_o,
  output      tick_res_t                          res_o,
  output      logic [$clog2(QUEUE_DEPTH+1)-1:0]   qlen_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  minute_t            tick_q, tick_d;
  logic [SVC_W-1:0]   work_q, work_d, work_load;
  logic [COUNT_W-1:0] enq_q, enq_d;
  logic [COUNT_W-1:0] served_q, served_d;
  logic [COUNT_W-1:0] cur_q, cur_d;
  logic [WAIT_W-1:0]  wsum_q, wsum_d;
  logic               busy_q, busy_d;

  logic               push, pop, dropped, idle;
  logic [CNT_W-1:0]   count_pushed;
  minute_t            entered, wait_ticks;
  logic [WAIT_W:0]    wsum_add;

  // queue side: push unless full, pop when the server is free and a job waits
  always_comb begin
    tick_d       = tick_q + 1'b1;
    push         = arrival_i && (count_i != CNT_FULL);
    dropped      = arrival_i && (count_i == CNT_FULL);
    count_pushed = count_i + CNT_W'(push);
    idle         = (work_q == '0);
    pop          = idle && (count_pushed != '0);
    // an empty queue hands over the job that arrives now
    entered      = (count_i == '0) ? tick_d : front_i;
    wait_ticks   = tick_d - entered;
  end

  // counters and server state
  always_comb begin
    enq_d    = enq_q;
    served_d = served_q;
    cur_d    = cur_q;
    wsum_d   = wsum_q;
    busy_d   = busy_q;
    wsum_add = {1'b0, wsum_q} + (WAIT_W + 1)'(wait_ticks);

    if (push && (enq_q != COUNT_MAX)) begin
      enq_d = enq_q + 1'b1;
    end
    if (idle && (count_pushed == '0)) begin
      busy_d = 1'b0;
    end
    if (pop) begin
      wsum_d   = wsum_add[WAIT_W] ? WAIT_MAX : wsum_add[WAIT_W-1:0];
      served_d = (served_q != COUNT_MAX) ? served_q + 1'b1 : served_q;
      cur_d    = served_d;
      busy_d   = 1'b1;
    end
    work_load = pop ? svc_time_i : work_q;
    work_d    = (work_load != '0) ? work_load - 1'b1 : work_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      work_q   <= '0;
      enq_q    <= '0;
      served_q <= '0;
      cur_q    <= '0;
      wsum_q   <= '0;
      busy_q   <= 1'b0;
    end else if (step_i) begin
      tick_q   <= tick_d;
      work_q   <= work_d;
      enq_q    <= enq_d;
      served_q <= served_d;
      cur_q    <= cur_d;
      wsum_q   <= wsum_d;
      busy_q   <= busy_d;
    end
  end

  // outputs for this tick
  always_comb begin
    ctrl_o.push           = step_i && push;
    ctrl_o.pop            = step_i && pop;
    res_o.minute          = tick_d;
    res_o.arrived_job     = push ? enq_d : '0;
    res_o.arrival_dropped = dropped;
    res_o.job_in_service  = (busy_d && (cur_d != '0)) ? cur_d : '0;
    res_o.busy_res        = busy_d;
    res_o.jobs_done       = served_d;
    res_o.wait_total      = wsum_d;
    qlen_o                = count_pushed - CNT_W'(pop);
  end

endmodule

`default_nettype wire
